[rtl/bc_pkg.sv]
// Shared types, register indexes and sign helpers for the barometer compensation block.
`timescale 1ns / 1ps
package bc_pkg;

	typedef logic [63:0] word64_t;
	typedef logic [31:0] word32_t;

	typedef enum logic [1:0] {
		REG_TEMP       = 2'd0,
		REG_PRESS_LOW  = 2'd1,
		REG_PRESS_HIGH = 2'd2,
		REG_PRESS_NINE = 2'd3
	} reg_index_t;

	localparam int unsigned DIV_BITS = 64;

	function automatic word64_t sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic word32_t sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

[rtl/bc_mul64.sv]
// Two-stage multiplier that returns the low 64 bits of a 64 by 64 bit product.
`timescale 1ns / 1ps
module bc_mul64
	import bc_pkg::*;
(
	input  logic    clk,
	input  word64_t a,
	input  word64_t b,
	output word64_t p
);

	word64_t ll_s1;
	word32_t lh_s1;
	word32_t hl_s1;

	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= a[31:0] * b[63:32];
		hl_s1 <= a[63:32] * b[31:0];
		p     <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
	end

endmodule

[rtl/bc_div.sv]
// Pipelined truncating signed 64-bit divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bc_div
	import bc_pkg::*;
(
	input  logic    clk,
	input  word64_t dividend,
	input  word64_t divisor,
	output word64_t quotient
);

	word64_t rem_s [0:DIV_BITS];
	word64_t quo_s [0:DIV_BITS];
	word64_t dvs_s [0:DIV_BITS];
	logic    neg_s [0:DIV_BITS];

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		quo_s[0] <= dividend[63] ? (64'd0 - dividend) : dividend;
		dvs_s[0] <= divisor[63] ? (64'd0 - divisor) : divisor;
		neg_s[0] <= dividend[63] ^ divisor[63];
	end

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
		logic [64:0] shifted;
		logic [64:0] trial;
		assign shifted = {rem_s[i], quo_s[i][63]};
		assign trial   = shifted - {1'b0, dvs_s[i]};
		always_ff @(posedge clk) begin
			rem_s[i+1] <= trial[64] ? shifted[63:0] : trial[63:0];
			quo_s[i+1] <= {quo_s[i][62:0], ~trial[64]};
			dvs_s[i+1] <= dvs_s[i];
			neg_s[i+1] <= neg_s[i];
		end
	end

	always_ff @(posedge clk) begin
		quotient <= neg_s[DIV_BITS] ? (64'd0 - quo_s[DIV_BITS]) : quo_s[DIV_BITS];
	end

endmodule

[rtl/barometer_compensation.sv]
// Top level of the barometer compensation pipeline.
`timescale 1ns / 1ps
// Usage:
// A sample pair is accepted at a rising edge where start is high and busy is low.
// Busy stays low, so a new pair may be started in every cycle.
// Each pair gives one result beat: done is high for exactly one cycle together with
// temperature_centi, pressure_q24_8 and zero_divisor, once the pair leaves the pipeline.
// Results leave in the order the pairs were started, at one beat per cycle.
// The pipeline is built around the 64-stage radix-2 divider, one quotient bit per stage,
// and the 64-bit multipliers around it.
// The receiver cannot stall the block; every beat must be taken when done is high.
// Coefficients are written through the cfg channel (index, data, valid, ready);
// cfg_ready is always high. The user must write only while no sample is in flight;
// the block does not enforce this. Reset clears the coefficient registers and all
// pipeline valid bits at once; no pass is needed before the first sample.
module barometer_compensation
	import bc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic        done,
	output logic signed [31:0] temperature_centi,
	output logic [31:0] pressure_q24_8,
	output logic        zero_divisor,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LAST = 87;

	logic [47:0] temp_q;
	word64_t     plow_q;
	word64_t     phigh_q;
	logic [15:0] p9_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			p9_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_TEMP:       temp_q  <= cfg_data[47:0];
				REG_PRESS_LOW:  plow_q  <= cfg_data;
				REG_PRESS_HIGH: phigh_q <= cfg_data;
				REG_PRESS_NINE: p9_q    <= cfg_data[15:0];
				default:        temp_q  <= temp_q;
			endcase
		end
	end

	word32_t t1, t2, t3;
	word64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, temp_q[15:0]};
	assign t2 = sx16_32(temp_q[31:16]);
	assign t3 = sx16_32(temp_q[47:32]);
	assign p1 = {48'd0, plow_q[15:0]};
	assign p2 = sx16_64(plow_q[31:16]);
	assign p3 = sx16_64(plow_q[47:32]);
	assign p4 = sx16_64(plow_q[63:48]);
	assign p5 = sx16_64(phigh_q[15:0]);
	assign p6 = sx16_64(phigh_q[31:16]);
	assign p7 = sx16_64(phigh_q[47:32]);
	assign p8 = sx16_64(phigh_q[63:48]);
	assign p9 = sx16_64(p9_q);

	logic [LAST:1] vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[LAST-1:1], start && !busy};
		end
	end

	logic [19:0] adct_s1;
	logic [19:0] adcp_s [1:12];
	word32_t     a_s2, b_s2, m1_s3, bb_s3, tv1_s4, bbs_s4, tv1_s5, m3_s5, tfine_s6;
	word32_t     tc_s [7:LAST-1];
	logic        zf_s [16:LAST-1];
	word64_t     v1_s7;
	word64_t     aa_s9, b5_s9, c2_s9, b5_s10, c2_s10, b5_s11, c2_s11, dd_s11, ee_s11;
	word64_t     v2_s12, y_s12, n_s13, ff_s14, gg_s15, dv_s15;
	word64_t     q_s81;
	word64_t     q_s [82:85];
	word64_t     ps_s82, ps_s83, hh_s83, ii_s83, w2_s84, w2_s85, jj_s85, sum_s86;
	word32_t     tf5;
	word64_t     ps_81, res_86;

	assign tf5    = {tfine_s6[29:0], 2'b00} + tfine_s6 + 32'd128;
	assign ps_81  = 64'($signed(q_s81) >>> 13);
	assign res_86 = 64'($signed(sum_s86) >>> 8) + {p7[59:0], 4'd0};

	always_ff @(posedge clk) begin
		adct_s1   <= raw_temperature;
		adcp_s[1] <= raw_pressure;
		for (int i = 2; i <= 12; i++) begin
			adcp_s[i] <= adcp_s[i-1];
		end
		a_s2     <= {15'd0, adct_s1[19:3]} - {t1[30:0], 1'b0};
		b_s2     <= {16'd0, adct_s1[19:4]} - t1;
		m1_s3    <= a_s2 * t2;
		bb_s3    <= b_s2 * b_s2;
		tv1_s4   <= 32'($signed(m1_s3) >>> 11);
		bbs_s4   <= 32'($signed(bb_s3) >>> 12);
		tv1_s5   <= tv1_s4;
		m3_s5    <= bbs_s4 * t3;
		tfine_s6 <= tv1_s5 + 32'($signed(m3_s5) >>> 14);
		tc_s[7]  <= 32'($signed(tf5) >>> 8);
		v1_s7    <= {{32{tfine_s6[31]}}, tfine_s6} - 64'd128000;
		for (int i = 8; i <= LAST-1; i++) begin
			tc_s[i] <= tc_s[i-1];
		end
		b5_s10 <= b5_s9;
		c2_s10 <= c2_s9;
		b5_s11 <= b5_s10;
		c2_s11 <= c2_s10;
		v2_s12 <= dd_s11 + {b5_s11[46:0], 17'd0} + {p4[28:0], 35'd0};
		y_s12  <= (64'd1 << 47) + 64'($signed(ee_s11) >>> 8) + {c2_s11[51:0], 12'd0};
		n_s13  <= {(64'd1048576 - {44'd0, adcp_s[12]}) << 31} - v2_s12;
		dv_s15 <= 64'($signed(ff_s14) >>> 33);
		zf_s[16] <= (dv_s15 == 64'd0);
		for (int i = 17; i <= LAST-1; i++) begin
			zf_s[i] <= zf_s[i-1];
		end
		q_s[82] <= q_s81;
		for (int i = 83; i <= 85; i++) begin
			q_s[i] <= q_s[i-1];
		end
		ps_s82  <= ps_81;
		ps_s83  <= ps_s82;
		w2_s84  <= 64'($signed(ii_s83) >>> 19);
		w2_s85  <= w2_s84;
		sum_s86 <= q_s[85] + 64'($signed(jj_s85) >>> 25) + w2_s85;
		temperature_centi <= $signed(tc_s[LAST-1]);
		zero_divisor      <= zf_s[LAST-1];
		if (zf_s[LAST-1] || res_86[63]) begin
			pressure_q24_8 <= 32'd0;
		end else if (res_86[62:32] != 31'd0) begin
			pressure_q24_8 <= 32'hFFFF_FFFF;
		end else begin
			pressure_q24_8 <= res_86[31:0];
		end
	end

	assign done = vld[LAST];

	bc_mul64 u_mul_a (.clk(clk), .a(v1_s7),  .b(v1_s7),  .p(aa_s9));
	bc_mul64 u_mul_b (.clk(clk), .a(v1_s7),  .b(p5),     .p(b5_s9));
	bc_mul64 u_mul_c (.clk(clk), .a(v1_s7),  .b(p2),     .p(c2_s9));
	bc_mul64 u_mul_d (.clk(clk), .a(aa_s9),  .b(p6),     .p(dd_s11));
	bc_mul64 u_mul_e (.clk(clk), .a(aa_s9),  .b(p3),     .p(ee_s11));
	bc_mul64 u_mul_f (.clk(clk), .a(y_s12),  .b(p1),     .p(ff_s14));
	bc_mul64 u_mul_g (.clk(clk), .a(n_s13),  .b(64'd3125), .p(gg_s15));
	bc_mul64 u_mul_h (.clk(clk), .a(ps_81),  .b(p9),     .p(hh_s83));
	bc_mul64 u_mul_i (.clk(clk), .a(q_s81),  .b(p8),     .p(ii_s83));
	bc_mul64 u_mul_j (.clk(clk), .a(hh_s83), .b(ps_s83), .p(jj_s85));

	bc_div u_div (
		.clk      (clk),
		.dividend (gg_s15),
		.divisor  (dv_s15),
		.quotient (q_s81)
	);

endmodule

[rtl/bc_checker.sv]
// Port-level checker for the barometer compensation block and its bind.
`timescale 1ns / 1ps
module bc_checker
	import bc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] pressure_q24_8,
	input logic        zero_divisor
);

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 87))
		else $error("Result beat without a matching start.");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##87 done)
		else $error("Accepted sample produced no result beat.");

	a_zero_div_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divisor) |-> (pressure_q24_8 == 32'd0))
		else $error("Zero divisor beat carries a nonzero pressure.");

endmodule

bind barometer_compensation bc_checker u_bc_checker (.*);
